FILE: rtl/dtw_pkg.sv
`timescale 1ns / 1ps

package dtw_pkg;

    // Accepted year window
    localparam logic [13:0] YEAR_MIN = 14'd2000;
    localparam logic [13:0] YEAR_MAX = 14'd2099;

    // Field limits
    localparam logic [4:0] HOUR_MAX   = 5'd23;
    localparam logic [5:0] MINUTE_MAX = 6'd59;
    localparam logic [5:0] SECOND_MAX = 6'd59;

    // Month codes
    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_MAR = 4'd3;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_MAY = 4'd5;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_JUL = 4'd7;
    localparam logic [3:0] MONTH_AUG = 4'd8;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_OCT = 4'd10;
    localparam logic [3:0] MONTH_NOV = 4'd11;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    // Weekday codes
    localparam logic [2:0] WEEKDAY_NONE   = 3'd0;
    localparam logic [2:0] WEEKDAY_SUNDAY = 3'd7;

    // Reciprocal for y / 25 on 14-bit years: (y * 20972) >> 19 is exact
    localparam logic [14:0] RECIP_25  = 15'd20972;
    localparam int          SHIFT_25  = 19;
    // Reciprocal for x / 7 on 8-bit sums: (x * 293) >> 11 is exact
    localparam logic [8:0]  RECIP_7   = 9'd293;
    localparam int          SHIFT_7   = 11;

    // Weekday residue of the year terms when the shifted year is 1999
    localparam logic [7:0]  YEAR_1999_RES = 8'd5;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [5:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } dtw_in_t;

    typedef struct packed {
        logic       valid_res;
        logic [2:0] weekday;
        logic [6:0] year_offset;
        logic [4:0] month_length;
    } dtw_out_t;

    // Days in a month, common year; zero for a code that is no month
    function automatic logic [4:0] base_month_length(input logic [3:0] month);
        logic [4:0] days;
        case (month)
            MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
            MONTH_AUG, MONTH_OCT, MONTH_DEC:   days = 5'd31;
            MONTH_APR, MONTH_JUN, MONTH_SEP,
            MONTH_NOV:                         days = 5'd30;
            MONTH_FEB:                         days = 5'd28;
            default:                           days = 5'd0;
        endcase
        return days;
    endfunction

    // Weekday offset of the first of each month
    function automatic logic [2:0] month_shift(input logic [3:0] month);
        logic [2:0] sh;
        case (month)
            MONTH_JAN: sh = 3'd0;
            MONTH_FEB: sh = 3'd3;
            MONTH_MAR: sh = 3'd2;
            MONTH_APR: sh = 3'd5;
            MONTH_MAY: sh = 3'd0;
            MONTH_JUN: sh = 3'd3;
            MONTH_JUL: sh = 3'd5;
            MONTH_AUG: sh = 3'd1;
            MONTH_SEP: sh = 3'd4;
            MONTH_OCT: sh = 3'd6;
            MONTH_NOV: sh = 3'd2;
            MONTH_DEC: sh = 3'd4;
            default:   sh = 3'd0;
        endcase
        return sh;
    endfunction

endpackage

FILE: rtl/dtw_chan_if.sv
`timescale 1ns / 1ps

interface dtw_chan_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/dtw_calc.sv
`timescale 1ns / 1ps

module dtw_calc (
    input  dtw_pkg::dtw_in_t  din,
    output dtw_pkg::dtw_out_t dout
);

    logic [28:0] prod25;
    logic [9:0]  quot25;
    logic [13:0] back25;
    logic        div4;
    logic        div16;
    logic        div25;
    logic        leap;
    logic [4:0]  mlen;
    logic        year_ok;
    logic        ok;
    logic [6:0]  offset;
    logic        early;
    logic        wrap;
    logic [6:0]  shifted;
    logic [7:0]  year_res;
    logic [7:0]  total;
    logic [17:0] prod7;
    logic [5:0]  quot7;
    logic [7:0]  back7;
    logic [7:0]  rem7;
    logic [2:0]  wd;

    // Leap rule: y%400 == y%16 && y%25, y%100 == y%4 && y%25
    assign prod25 = 29'(din.year) * 29'(dtw_pkg::RECIP_25);
    assign quot25 = prod25[dtw_pkg::SHIFT_25 +: 10];
    assign back25 = 14'({quot25, 4'b0}) + 14'({quot25, 3'b0}) + 14'(quot25);
    assign div4   = (din.year[1:0] == 2'b00);
    assign div16  = (din.year[3:0] == 4'b0000);
    assign div25  = (back25 == din.year);
    assign leap   = div4 && (div16 || !div25);

    // Month length, with the leap day on February
    always_comb
    begin
        mlen = dtw_pkg::base_month_length(din.month);
        if ((din.month == dtw_pkg::MONTH_FEB) && leap)
        begin
            mlen = 5'd29;
        end
    end

    // Range checks
    assign year_ok = (din.year >= dtw_pkg::YEAR_MIN) && (din.year <= dtw_pkg::YEAR_MAX);
    assign ok      = year_ok && (mlen != 5'd0)
                     && (din.day != 6'd0) && (din.day <= {1'b0, mlen})
                     && (din.hour <= dtw_pkg::HOUR_MAX)
                     && (din.minute <= dtw_pkg::MINUTE_MAX)
                     && (din.second <= dtw_pkg::SECOND_MAX);

    // Year terms mod 7: for 2000+r the sum y+y/4-y/100+y/400 is 2485+r+r/4, 2485 = 7*355
    assign offset   = 7'(din.year - dtw_pkg::YEAR_MIN);
    assign early    = (din.month == dtw_pkg::MONTH_JAN) || (din.month == dtw_pkg::MONTH_FEB);
    assign wrap     = early && (offset == 7'd0);
    assign shifted  = offset - 7'(early);
    assign year_res = wrap ? dtw_pkg::YEAR_1999_RES
                           : ({1'b0, shifted} + {3'b0, shifted[6:2]});
    assign total    = year_res + 8'(dtw_pkg::month_shift(din.month)) + 8'(din.day);

    // Reduce mod 7 by reciprocal
    assign prod7 = 18'(total) * 18'(dtw_pkg::RECIP_7);
    assign quot7 = prod7[dtw_pkg::SHIFT_7 +: 6];
    assign back7 = 8'({quot7, 3'b0}) - 8'(quot7);
    assign rem7  = total - back7;
    assign wd    = (rem7[2:0] == 3'd0) ? dtw_pkg::WEEKDAY_SUNDAY : rem7[2:0];

    // Gate weekday and year offset on a legal input; month length passes through
    assign dout.valid_res    = ok;
    assign dout.weekday      = ok ? wd : dtw_pkg::WEEKDAY_NONE;
    assign dout.year_offset  = ok ? offset : 7'd0;
    assign dout.month_length = mlen;

endmodule

FILE: rtl/datetime_check_and_weekday_core.sv
`timescale 1ns / 1ps
// Channel | Dir | Payload
// req     | in  | year, month, day, hour, minute, second
// rsp     | out | valid_res, weekday, year_offset, month_length
//
// One request is taken every cycle while req.ready is high; each response
// passes through an input register and then a result register after its request is taken.
// Reset clears both stage valid flags; nothing else needs a reset.
// A stalled response holds in the result register while the input register
// still takes a request; req.ready drops only when both stages are full.

module datetime_check_and_weekday_core (
    input  logic           clk,
    input  logic           rst_n,
    dtw_chan_if.sink       req,
    dtw_chan_if.source     rsp
);

    logic              in_valid_reg;
    logic              in_valid_next;
    dtw_pkg::dtw_in_t  in_data_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    dtw_pkg::dtw_out_t out_data_reg;
    dtw_pkg::dtw_out_t out_data_next;
    logic              out_free;

    // Advance when the result slot is empty or being taken
    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = !in_valid_reg || out_free;

    assign in_valid_next  = req.ready ? req.valid : in_valid_reg;
    assign out_valid_next = out_free ? in_valid_reg : out_valid_reg;

    dtw_calc u_calc (
        .din  (in_data_reg),
        .dout (out_data_next)
    );

    // Hold stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load payloads
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_data_reg <= req.data;
        end
        if (out_free && in_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

endmodule

FILE: rtl/dtw_checker.sv
`timescale 1ns / 1ps

module dtw_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input dtw_pkg::dtw_out_t rsp_data
);

    // Stalled response stays put
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
        else $error("response changed while stalled");

    // A legal date carries a weekday, an in-range offset and a real month length
    a_valid_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.valid_res) |->
        ((rsp_data.weekday != 3'd0) && (rsp_data.year_offset <= 7'd99)
         && (rsp_data.month_length >= 5'd28)))
        else $error("legal date with bad derived fields");

    // An illegal date zeroes weekday and offset
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_data.valid_res) |->
        ((rsp_data.weekday == 3'd0) && (rsp_data.year_offset == 7'd0)))
        else $error("illegal date with nonzero weekday or offset");

    // A request taken while no response is pending is followed by a valid response
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && !rsp_valid) |=> ##1 rsp_valid)
        else $error("response missing after request");

endmodule

bind datetime_check_and_weekday_core dtw_checker u_dtw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);
